// ===== rtl/tbs_pkg.sv =====
// Shared widths, register codes, reset values and datapath types.
// No dependencies; the interfaces, lane, merge, top level and bench import this package.
package tbs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int OFFSET_W = 9;
   localparam int Q16_W    = 17;
   localparam int LIMIT_W  = 8;
   localparam int DWELL_W  = 10;
   localparam int CSR_W    = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic [Q16_W-1:0]   Q16_ONE     = 17'd65536;
   localparam logic [DWELL_W-1:0] DWELL_MAX   = 10'd1023;

   localparam logic [Q16_W-1:0]   ALPHA_RST   = 17'd19661;
   localparam logic [Q16_W-1:0]   GAIN_RST    = 17'd39322;
   localparam logic [LIMIT_W-1:0] LIM_H_RST   = 8'd185;
   localparam logic [LIMIT_W-1:0] LIM_V_RST   = 8'd231;
   localparam logic [LIMIT_W-1:0] THRESH_RST  = 8'd10;
   localparam logic [DWELL_W-1:0] DWELL_RST   = 10'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA     = 3'd0,
      CSR_GAIN      = 3'd1,
      CSR_LIMIT_H   = 3'd2,
      CSR_LIMIT_V   = 3'd3,
      CSR_THRESHOLD = 3'd4,
      CSR_DWELL     = 3'd5
   } csr_index_type;

   // smoothing coefficients, already clamped to one
   typedef struct packed {
      logic [Q16_W-1:0] alpha;
      logic [Q16_W-1:0] one_minus_alpha;
      logic [Q16_W-1:0] gain;
   } coef_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] threshold;
      logic [DWELL_W-1:0] dwell;
   } level_cfg_type;

endpackage

// ===== rtl/tbs_req_if.sv =====
// Sample channel: valid/ready handshake carrying one two-axis sample.
// Depends on tbs_pkg for the sample width.
interface tbs_req_if;
   import tbs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] accel_x;
   logic signed [SAMPLE_W-1:0] accel_y;

   modport source (output valid, output accel_x, output accel_y, input ready);
   modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

// ===== rtl/tbs_rsp_if.sv =====
// Result channel: valid/ready handshake carrying offsets and level events.
// Depends on tbs_pkg for the offset width.
interface tbs_rsp_if;
   import tbs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [OFFSET_W-1:0] offset_horizontal;
   logic signed [OFFSET_W-1:0] offset_vertical;
   logic                       is_level;
   logic                       became_level;
   logic                       left_level;

   modport source (output valid, output offset_horizontal, output offset_vertical,
                   output is_level, output became_level, output left_level,
                   input ready);
   modport sink   (input valid, input offset_horizontal, input offset_vertical,
                   input is_level, input became_level, input left_level,
                   output ready);
endinterface

// ===== rtl/tbs_lane.sv =====
// One axis of the smoother: weighted average, gain, clamp, kept as history.
// Four register stages; depends on tbs_pkg.
module tbs_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tbs_pkg::SAMPLE_W-1:0] sample,
   input  tbs_pkg::coef_type                   coef,
   input  logic [tbs_pkg::LIMIT_W-1:0]         limit,
   output logic signed [tbs_pkg::OFFSET_W-1:0] offset,
   output logic                                done
);
   import tbs_pkg::*;

   localparam int P1_W   = SAMPLE_W + Q16_W + 1;   // 34
   localparam int P2_W   = OFFSET_W + Q16_W + 1;   // 27
   localparam int SM_W   = P1_W - Q16_W;           // 17
   localparam int PR_W   = SM_W + Q16_W + 1;       // 35
   localparam int SC_W   = PR_W - (Q16_W - 1);     // 19

   logic [2:0]              stage_ff, stage_in;
   logic                    done_ff, done_in;
   logic signed [P1_W-1:0]  p1_ff, p1_in;
   logic signed [P2_W-1:0]  p2_ff, p2_in;
   logic signed [SM_W-1:0]  sm_ff, sm_in;
   logic signed [PR_W-1:0]  pr_ff, pr_in;
   logic signed [OFFSET_W-1:0] off_ff, off_in;

   logic signed [P1_W-1:0]  p2_x2, num, num_b;
   logic signed [PR_W-1:0]  pr_b;
   logic signed [SC_W-1:0]  sc, lim_pos, lim_neg;

   always_comb begin
      stage_in = {stage_ff[1:0], start};
      done_in  = stage_ff[2];

      p1_in = sample * $signed({1'b0, coef.alpha});
      p2_in = off_ff * $signed({1'b0, coef.one_minus_alpha});

      // sum, then divide by 2^17 rounding toward zero
      p2_x2 = {{(P1_W-P2_W-1){p2_ff[P2_W-1]}}, p2_ff, 1'b0};
      num   = p1_ff + p2_x2;
      num_b = num + $signed({{(P1_W-Q16_W){1'b0}}, {Q16_W{num[P1_W-1]}}});
      sm_in = num_b[P1_W-1:Q16_W];

      pr_in = sm_ff * $signed({1'b0, coef.gain});

      // divide by 2^16 rounding toward zero, then clamp
      pr_b = pr_ff + $signed({{(PR_W-Q16_W+1){1'b0}}, {(Q16_W-1){pr_ff[PR_W-1]}}});
      sc   = pr_b[PR_W-1:Q16_W-1];
      lim_pos = $signed({{(SC_W-LIMIT_W){1'b0}}, limit});
      lim_neg = -lim_pos;
      priority if (sc > lim_pos) begin
         off_in = lim_pos[OFFSET_W-1:0];
      end else if (sc < lim_neg) begin
         off_in = lim_neg[OFFSET_W-1:0];
      end else begin
         off_in = sc[OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
         off_ff   <= '0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
         if (stage_ff[2]) begin
            off_ff <= off_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (stage_ff[0]) begin
         sm_ff <= sm_in;
      end
      if (stage_ff[1]) begin
         pr_ff <= pr_in;
      end
   end

   assign offset = off_ff;
   assign done   = done_ff;
endmodule

// ===== rtl/tbs_merge.sv =====
// Combines both lane offsets: dwell counter, level flag and result register.
// Depends on tbs_pkg and tbs_rsp_if.
module tbs_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                lane_done,
   input  logic signed [tbs_pkg::OFFSET_W-1:0] off_h,
   input  logic signed [tbs_pkg::OFFSET_W-1:0] off_v,
   input  tbs_pkg::level_cfg_type              level_cfg,
   output logic                                fire,
   tbs_rsp_if.source                           rsp_chan
);
   import tbs_pkg::*;

   logic                       pend_ff, pend_in;
   logic                       valid_ff, valid_in;
   logic [DWELL_W-1:0]         cnt_ff, cnt_in;
   logic                       flag_ff, flag_in;
   logic signed [OFFSET_W-1:0] oh_ff, ov_ff;
   logic                       became_ff, became_in, left_ff, left_in;

   logic [OFFSET_W-1:0] neg_h, neg_v;
   logic [LIMIT_W-1:0]  mag_h, mag_v;
   logic [DWELL_W-1:0]  cnt_inc;
   logic                lvl;

   always_comb begin
      fire  = (lane_done || pend_ff) && (!valid_ff || rsp_chan.ready);
      neg_h = -off_h;
      neg_v = -off_v;
      mag_h = off_h[OFFSET_W-1] ? neg_h[LIMIT_W-1:0] : off_h[LIMIT_W-1:0];
      mag_v = off_v[OFFSET_W-1] ? neg_v[LIMIT_W-1:0] : off_v[LIMIT_W-1:0];
      lvl   = (mag_h < level_cfg.threshold) && (mag_v < level_cfg.threshold);
      cnt_inc = (cnt_ff == DWELL_MAX) ? cnt_ff : cnt_ff + 1'b1;

      pend_in   = (lane_done || pend_ff) && !fire;
      valid_in  = fire || (valid_ff && !rsp_chan.ready);
      cnt_in    = cnt_ff;
      flag_in   = flag_ff;
      became_in = 1'b0;
      left_in   = 1'b0;
      if (lvl) begin
         cnt_in = cnt_inc;
         if (!flag_ff && cnt_inc >= level_cfg.dwell) begin
            flag_in   = 1'b1;
            became_in = 1'b1;
         end
      end else begin
         cnt_in  = '0;
         flag_in = 1'b0;
         left_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         flag_ff  <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
         if (fire) begin
            cnt_ff  <= cnt_in;
            flag_ff <= flag_in;
         end
      end
   end

   // hold the beat until taken
   always_ff @(posedge clock) begin
      if (fire) begin
         oh_ff     <= off_h;
         ov_ff     <= off_v;
         became_ff <= became_in;
         left_ff   <= left_in;
      end
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.offset_horizontal = oh_ff;
   assign rsp_chan.offset_vertical   = ov_ff;
   assign rsp_chan.is_level          = flag_ff;
   assign rsp_chan.became_level      = became_ff;
   assign rsp_chan.left_level        = left_ff;
endmodule

// ===== rtl/tilt_bubble_smoother_level_detect.sv =====
// Channel   | role            | carries
// req_chan  | sink, sample    | accel_x, accel_y
// rsp_chan  | source, result  | offsets, is_level, became_level, left_level
// csr_*     | register write  | csr_index, csr_wdata
//
// A sample passes from accept to result through four lane stages (two
// multiply stages per axis) and the merge stage; one sample is in flight.
// Reset is synchronous: registers to defaults, history and flag to zero.
// The result register holds a beat while the sink stalls; the next sample is
// still accepted and waits in the merge stage until the register frees.
// Depends on tbs_pkg, tbs_req_if, tbs_rsp_if, tbs_lane and tbs_merge.
module tilt_bubble_smoother_level_detect (
   input  logic                                 clock,
   input  logic                                 reset,
   tbs_req_if.sink                              req_chan,
   tbs_rsp_if.source                            rsp_chan,
   input  logic                                 csr_we,
   input  tbs_pkg::csr_index_type               csr_index,
   input  logic [tbs_pkg::CSR_W-1:0]            csr_wdata
);
   import tbs_pkg::*;

   logic [Q16_W-1:0]   alpha_ff, gain_ff;
   logic [LIMIT_W-1:0] lim_h_ff, lim_v_ff, thresh_ff;
   logic [DWELL_W-1:0] dwell_ff;
   logic               busy_ff, busy_in;

   logic               start, fire, done_h, done_v;
   logic [Q16_W-1:0]   alpha_sat, gain_sat;
   coef_type           coef;
   level_cfg_type      level_cfg;
   logic signed [OFFSET_W-1:0] off_h, off_v;

   always_comb begin
      start     = req_chan.valid && !busy_ff;
      busy_in   = start || (busy_ff && !fire);
      alpha_sat = (alpha_ff > Q16_ONE) ? Q16_ONE : alpha_ff;
      gain_sat  = (gain_ff > Q16_ONE) ? Q16_ONE : gain_ff;
      coef.alpha           = alpha_sat;
      coef.one_minus_alpha = Q16_ONE - alpha_sat;
      coef.gain            = gain_sat;
      level_cfg.threshold  = thresh_ff;
      level_cfg.dwell      = dwell_ff;
   end

   assign req_chan.ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         alpha_ff  <= ALPHA_RST;
         gain_ff   <= GAIN_RST;
         lim_h_ff  <= LIM_H_RST;
         lim_v_ff  <= LIM_V_RST;
         thresh_ff <= THRESH_RST;
         dwell_ff  <= DWELL_RST;
      end else begin
         busy_ff <= busy_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ALPHA:     alpha_ff  <= csr_wdata;
               CSR_GAIN:      gain_ff   <= csr_wdata;
               CSR_LIMIT_H:   lim_h_ff  <= csr_wdata[LIMIT_W-1:0];
               CSR_LIMIT_V:   lim_v_ff  <= csr_wdata[LIMIT_W-1:0];
               CSR_THRESHOLD: thresh_ff <= csr_wdata[LIMIT_W-1:0];
               CSR_DWELL:     dwell_ff  <= csr_wdata[DWELL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // horizontal follows sensor y, vertical follows sensor x
   tbs_lane u_lane_h (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sample (req_chan.accel_y),
      .coef   (coef),
      .limit  (lim_h_ff),
      .offset (off_h),
      .done   (done_h)
   );

   tbs_lane u_lane_v (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .sample (req_chan.accel_x),
      .coef   (coef),
      .limit  (lim_v_ff),
      .offset (off_v),
      .done   (done_v)
   );

   tbs_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_done (done_h && done_v),
      .off_h     (off_h),
      .off_v     (off_v),
      .level_cfg (level_cfg),
      .fire      (fire),
      .rsp_chan  (rsp_chan)
   );
endmodule

// ===== rtl/tbs_checker.sv =====
// Port-level checks on the smoother over time, bound to the top level.
// Depends on tbs_req_if and tbs_rsp_if.
module tbs_checker (
   input logic       clock,
   input logic       reset,
   tbs_req_if.sink   req_chan,
   tbs_rsp_if.source rsp_chan
);

   // no result beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result beat right after reset");

   // one sample in flight: no accept on the cycle after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("sample accepted back to back");

   a_events_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.became_level && rsp_chan.left_level))
      else $error("became_level and left_level together");

   a_events_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.became_level) |-> rsp_chan.is_level)
      else $error("became_level without level flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.offset_horizontal)
          && $stable(rsp_chan.offset_vertical) && $stable(rsp_chan.is_level)))
      else $error("stalled result beat changed");

endmodule

bind tilt_bubble_smoother_level_detect tbs_checker u_tbs_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// ===== tb/tilt_bubble_smoother_level_detect_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the tilt-bubble smoother: a directed sample table, then
// random bursts under several register settings, checked against a local predictor.
// Depends on tbs_pkg, tbs_req_if, tbs_rsp_if and tilt_bubble_smoother_level_detect.
module tilt_bubble_smoother_level_detect_tb;
   import tbs_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int SEGMENTS    = 12;
   localparam int SEG_SAMPLES = 120;
   localparam int DIR_ROWS    = 22;

   typedef struct packed {
      logic [OFFSET_W-1:0] off_h;
      logic [OFFSET_W-1:0] off_v;
      logic                is_level;
      logic                became_level;
      logic                left_level;
   } tilt_result_type;

   typedef struct packed {
      logic [Q16_W-1:0]   alpha;
      logic [Q16_W-1:0]   gain;
      logic [LIMIT_W-1:0] lim_h;
      logic [LIMIT_W-1:0] lim_v;
      logic [LIMIT_W-1:0] thresh;
      logic [DWELL_W-1:0] dwell;
   } settings_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] ax;
      logic [SAMPLE_W-1:0] ay;
      logic [2:0]          setting;
      logic                known;
      tilt_result_type     want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   tbs_req_if sample_bus ();
   tbs_rsp_if result_bus ();

   tilt_bubble_smoother_level_detect dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (sample_bus),
      .rsp_chan  (result_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and its copy of the registers
   settings_type           cur_cfg = '{ALPHA_RST, GAIN_RST, LIM_H_RST, LIM_V_RST,
                                        THRESH_RST, DWELL_RST};
   logic signed [OFFSET_W-1:0] hist_h = '0;
   logic signed [OFFSET_W-1:0] hist_v = '0;
   logic [DWELL_W-1:0]     dwell_cnt = '0;
   logic                   level_on = 1'b0;

   tilt_result_type pending_results [$];
   int error_count = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 55;

   settings_type dir_settings [0:4] = '{
      '{ALPHA_RST, GAIN_RST, LIM_H_RST, LIM_V_RST, THRESH_RST, DWELL_RST},
      '{17'h1FFFF, 17'h1FFFF, 8'd255, 8'd0, 8'd0, 10'd0},
      '{Q16_ONE, Q16_ONE, 8'd255, 8'd255, 8'd255, 10'd0},
      '{17'd0, 17'd0, 8'd100, 8'd100, 8'd1, 10'd3},
      '{17'd32768, Q16_ONE, 8'd255, 8'd255, 8'd20, 10'd2}
   };

   // typed expectations only where the arithmetic collapses (clamps, unit weights, zero gain)
   directed_row_type directed_rows [0:DIR_ROWS-1] = '{
      '{16'sd0,      16'sd0,      3'd0, 1'b1, '{9'sd0,    9'sd0,    1'b0, 1'b0, 1'b0}},
      '{16'sd32767,  16'h8000,    3'd0, 1'b1, '{-9'sd185, 9'sd231,  1'b0, 1'b0, 1'b0}},
      '{16'h8000,    16'sd32767,  3'd0, 1'b0, '0},
      '{16'sd1,      -16'sd1,     3'd0, 1'b0, '0},
      '{16'sd32767,  16'sd32767,  3'd1, 1'b1, '{9'sd255,  9'sd0,    1'b0, 1'b0, 1'b0}},
      '{16'h8000,    16'h8000,    3'd1, 1'b1, '{-9'sd255, 9'sd0,    1'b0, 1'b0, 1'b0}},
      '{16'sd0,      16'sd0,      3'd1, 1'b1, '{9'sd0,    9'sd0,    1'b0, 1'b0, 1'b0}},
      '{16'sd0,      16'sd0,      3'd2, 1'b1, '{9'sd0,    9'sd0,    1'b1, 1'b1, 1'b0}},
      '{-16'sd7,     16'sd100,    3'd2, 1'b1, '{9'sd50,   -9'sd3,   1'b1, 1'b0, 1'b0}},
      '{16'sd32767,  16'sd0,      3'd2, 1'b1, '{9'sd0,    9'sd255,  1'b0, 1'b0, 1'b1}},
      '{16'sd508,    -16'sd509,   3'd2, 1'b1, '{-9'sd254, 9'sd254,  1'b1, 1'b1, 1'b0}},
      '{-16'sd511,   16'sd511,    3'd2, 1'b1, '{9'sd255,  -9'sd255, 1'b0, 1'b0, 1'b1}},
      '{16'sd32767,  16'h8000,    3'd3, 1'b1, '{9'sd0,    9'sd0,    1'b0, 1'b0, 1'b0}},
      '{16'sd123,    -16'sd456,   3'd3, 1'b1, '{9'sd0,    9'sd0,    1'b0, 1'b0, 1'b0}},
      '{-16'sd1,     16'sd1,      3'd3, 1'b1, '{9'sd0,    9'sd0,    1'b1, 1'b1, 1'b0}},
      '{16'sd0,      16'sd0,      3'd3, 1'b1, '{9'sd0,    9'sd0,    1'b1, 1'b0, 1'b0}},
      '{-16'sd3,     16'sd3,      3'd4, 1'b0, '0},
      '{16'sd400,    -16'sd400,   3'd4, 1'b0, '0},
      '{-16'sd40,    16'sd40,     3'd4, 1'b0, '0},
      '{16'sd0,      16'sd0,      3'd4, 1'b0, '0},
      '{16'sd0,      16'sd0,      3'd4, 1'b0, '0},
      '{16'sd0,      16'sd0,      3'd4, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_failure(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // weighted blend of sample and history, then gain, both truncated toward zero
   function automatic logic signed [OFFSET_W-1:0] smooth_offset(
         input logic signed [SAMPLE_W-1:0] sample,
         input logic signed [OFFSET_W-1:0] prev,
         input logic [LIMIT_W-1:0] lim);
      longint one, a, g, num, sm, sc, bound;
      one   = Q16_ONE;
      a     = (cur_cfg.alpha > Q16_ONE) ? Q16_ONE : cur_cfg.alpha;
      g     = (cur_cfg.gain > Q16_ONE) ? Q16_ONE : cur_cfg.gain;
      bound = lim;
      num   = longint'(sample) * a + 2 * longint'(prev) * (one - a);
      sm    = num / (2 * one);
      sc    = (sm * g) / one;
      if (sc > bound) sc = bound;
      if (sc < -bound) sc = -bound;
      return OFFSET_W'(sc);
   endfunction

   function automatic tilt_result_type predict_sample(input logic signed [SAMPLE_W-1:0] ax,
                                                      input logic signed [SAMPLE_W-1:0] ay);
      tilt_result_type r;
      longint mag_h, mag_v, thr;
      r.off_h = smooth_offset(ay, hist_h, cur_cfg.lim_h);
      r.off_v = smooth_offset(ax, hist_v, cur_cfg.lim_v);
      mag_h = longint'($signed(r.off_h));
      mag_v = longint'($signed(r.off_v));
      if (mag_h < 0) mag_h = -mag_h;
      if (mag_v < 0) mag_v = -mag_v;
      thr = cur_cfg.thresh;
      r.became_level = 1'b0;
      r.left_level   = 1'b0;
      if (mag_h < thr && mag_v < thr) begin
         if (dwell_cnt != DWELL_MAX) dwell_cnt++;
         if (!level_on && dwell_cnt >= cur_cfg.dwell) begin
            level_on = 1'b1;
            r.became_level = 1'b1;
         end
      end else begin
         dwell_cnt = '0;
         if (level_on) begin
            level_on = 1'b0;
            r.left_level = 1'b1;
         end
      end
      hist_h = r.off_h;
      hist_v = r.off_v;
      r.is_level = level_on;
      return r;
   endfunction

   function automatic logic [Q16_W-1:0] random_q16();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return Q16_ONE;
         2: return Q16_W'($urandom_range(65537, 131071));
         default: return Q16_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      s.alpha  = random_q16();
      s.gain   = random_q16();
      s.lim_h  = LIMIT_W'($urandom_range(0, 255));
      s.lim_v  = LIMIT_W'($urandom_range(0, 255));
      s.thresh = ($urandom_range(0, 4) == 0) ? LIMIT_W'($urandom_range(0, 255))
                                             : LIMIT_W'($urandom_range(0, 40));
      s.dwell  = ($urandom_range(0, 4) == 0) ? DWELL_W'($urandom_range(0, 1023))
                                             : DWELL_W'($urandom_range(0, 12));
      return s;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_extreme();
      unique case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // hold the beat until accepted, then queue what it must produce
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                              input logic signed [SAMPLE_W-1:0] ay,
                              input logic known,
                              input tilt_result_type typed);
      tilt_result_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         sample_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      sample_bus.valid   <= 1'b1;
      sample_bus.accel_x <= ax;
      sample_bus.accel_y <= ay;
      do @(posedge clock); while (!sample_bus.ready);
      predicted = predict_sample(ax, ay);
      pending_results.push_back(known ? typed : predicted);
   endtask

   task automatic drain_results();
      sample_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input settings_type s);
      write_reg(CSR_ALPHA, s.alpha);
      write_reg(CSR_GAIN, s.gain);
      write_reg(CSR_LIMIT_H, CSR_W'(s.lim_h));
      write_reg(CSR_LIMIT_V, CSR_W'(s.lim_v));
      write_reg(CSR_THRESHOLD, CSR_W'(s.thresh));
      write_reg(CSR_DWELL, CSR_W'(s.dwell));
      csr_we  <= 1'b0;
      cur_cfg = s;
   endtask

   // result side: check accepted beats, then pick next ready
   always @(posedge clock) begin
      tilt_result_type got, want;
      if (reset) begin
         result_bus.ready <= 1'b0;
      end else begin
         if (result_bus.valid && result_bus.ready) begin
            got = '{result_bus.offset_horizontal, result_bus.offset_vertical,
                    result_bus.is_level, result_bus.became_level, result_bus.left_level};
            if (pending_results.size() == 0) begin
               report_failure("result beat with no sample outstanding");
            end else begin
               want = pending_results.pop_front();
               if (got.off_h !== want.off_h)
                  report_failure($sformatf("offset_horizontal got %0d expected %0d",
                                           $signed(got.off_h), $signed(want.off_h)));
               if (got.off_v !== want.off_v)
                  report_failure($sformatf("offset_vertical got %0d expected %0d",
                                           $signed(got.off_v), $signed(want.off_v)));
               if (got.is_level !== want.is_level)
                  report_failure($sformatf("is_level got %b expected %b",
                                           got.is_level, want.is_level));
               if (got.became_level !== want.became_level)
                  report_failure($sformatf("became_level got %b expected %b",
                                           got.became_level, want.became_level));
               if (got.left_level !== want.left_level)
                  report_failure($sformatf("left_level got %b expected %b",
                                           got.left_level, want.left_level));
            end
         end
         result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int active_setting;
      int seg, remaining, burst, k, span, mode;
      logic signed [SAMPLE_W-1:0] ax, ay;
      settings_type s;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_ALPHA;
      csr_wdata          <= '0;
      sample_bus.valid   <= 1'b0;
      sample_bus.accel_x <= '0;
      sample_bus.accel_y <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      active_setting = 0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (int'(directed_rows[i].setting) != active_setting) begin
            drain_results();
            active_setting = int'(directed_rows[i].setting);
            apply_settings(dir_settings[active_setting]);
         end
         send_sample(directed_rows[i].ax, directed_rows[i].ay,
                     directed_rows[i].known, directed_rows[i].want);
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == SEGMENTS / 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 26;
         end else if (seg == 2 * SEGMENTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         unique case (seg)
            0: s = dir_settings[0];
            1: s = '{17'h1FFFF, 17'h1FFFF, 8'd255, 8'd255, 8'd255, 10'd1023};
            2: s = '0;
            default: s = random_settings();
         endcase
         drain_results();
         apply_settings(s);

         remaining = SEG_SAMPLES;
         while (remaining > 0) begin
            mode  = $urandom_range(0, 9);
            burst = 1;
            // long quiet runs let the dwell counter reach its target
            if (mode <= 5)
               burst = $urandom_range(1, (cur_cfg.dwell < 30) ? int'(cur_cfg.dwell) + 6 : 36);
            span = 2 * int'(cur_cfg.thresh) + 1;
            for (k = 0; k < burst && remaining > 0; k++) begin
               if (mode <= 5) begin
                  ax = SAMPLE_W'(int'($urandom_range(0, 2 * span)) - span);
                  ay = SAMPLE_W'(int'($urandom_range(0, 2 * span)) - span);
               end else if (mode <= 7) begin
                  ax = SAMPLE_W'($urandom);
                  ay = SAMPLE_W'($urandom);
               end else if (mode == 8) begin
                  ax = pick_extreme();
                  ay = pick_extreme();
               end else begin
                  ax = SAMPLE_W'($urandom);
                  ay = SAMPLE_W'(int'($urandom_range(0, 2 * span)) - span);
               end
               send_sample(ax, ay, 1'b0, '0);
               remaining--;
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== tilt_bubble_smoother_level_detect.f =====
rtl/tbs_pkg.sv
rtl/tbs_req_if.sv
rtl/tbs_rsp_if.sv
rtl/tbs_lane.sv
rtl/tbs_merge.sv
rtl/tilt_bubble_smoother_level_detect.sv
rtl/tbs_checker.sv
tb/tilt_bubble_smoother_level_detect_tb.sv
